// ===== hw/rtl/gpad_pkg.sv =====
// shared types, constants, and decode and event-value functions for the gamepad change-event block
`default_nettype none
package gpad_pkg;

  // event layout
  localparam int EVENT_COUNT = 22;
  localparam int AXIS_COUNT  = 6;
  localparam int BTN_COUNT   = 16;
  localparam int CODE_W      = 5;
  localparam int VAL_W       = 8;

  // event codes at the edges of each group
  localparam logic [CODE_W-1:0] EV_RIGHT_Y   = 5'd3;
  localparam logic [CODE_W-1:0] EV_LEFT_TRIG = 5'd20;
  localparam logic [CODE_W-1:0] EV_LAST      = 5'd21;

  // hat nibble codes, eight directions; the rest mean neutral
  localparam logic [3:0] HAT_N  = 4'h0;
  localparam logic [3:0] HAT_NE = 4'h1;
  localparam logic [3:0] HAT_E  = 4'h2;
  localparam logic [3:0] HAT_SE = 4'h3;
  localparam logic [3:0] HAT_S  = 4'h4;
  localparam logic [3:0] HAT_SW = 4'h5;
  localparam logic [3:0] HAT_W  = 4'h6;
  localparam logic [3:0] HAT_NW = 4'h7;

  typedef logic [AXIS_COUNT-1:0][VAL_W-1:0] axes_t;
  typedef logic [BTN_COUNT-1:0]             btns_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
    logic step;
  } gpad_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic changed;
    logic idx_last;
    logic out_free;
  } gpad_sts_t;

  // hat, face, shoulder, menu and system bits into the 16 button events
  function automatic btns_t decode_bits(input logic [7:0] hat_face,
                                        input logic [7:0] shoulder,
                                        input logic [7:0] sys);
    btns_t b;
    b = '0;
    case (hat_face[3:0])
      HAT_N:   b[3:0] = 4'b0001;
      HAT_NE:  b[3:0] = 4'b0011;
      HAT_E:   b[3:0] = 4'b0010;
      HAT_SE:  b[3:0] = 4'b0110;
      HAT_S:   b[3:0] = 4'b0100;
      HAT_SW:  b[3:0] = 4'b1100;
      HAT_W:   b[3:0] = 4'b1000;
      HAT_NW:  b[3:0] = 4'b1001;
      default: b[3:0] = 4'b0000;
    endcase
    b[7:4]   = hat_face[7:4];
    b[9:8]   = shoulder[1:0];
    b[13:10] = shoulder[7:4];
    b[15:14] = sys[1:0];
    return b;
  endfunction

  // value of one event from axis bytes and button bits
  function automatic logic [VAL_W-1:0] event_value(input axes_t a, input btns_t b,
                                                   input int idx);
    logic [VAL_W-1:0] v;
    if (idx <= int'(EV_RIGHT_Y)) begin
      v = a[idx];
    end else if (idx >= int'(EV_LEFT_TRIG)) begin
      v = a[idx - BTN_COUNT];
    end else begin
      v = {{(VAL_W-1){1'b0}}, b[idx - 4]};
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/gpad_ctrl.sv =====
// controller state machine: capture a report, then walk the 22 events
`default_nettype none
module gpad_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire gpad_pkg::gpad_sts_t sts,
  output gpad_pkg::gpad_cmd_t     cmd
);

  gpad_pkg::ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gpad_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      gpad_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = gpad_pkg::ST_SCAN;
        end
      end
      gpad_pkg::ST_SCAN: begin
        // a changed event waits for room in the output word
        cmd.emit = sts.changed && sts.out_free;
        cmd.step = !sts.changed || sts.out_free;
        if (cmd.step && sts.idx_last) begin
          state_nxt = gpad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gpad_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gpad_dp.sv =====
// datapath: current and previous event values, scan index, output word
`default_nettype none
module gpad_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [7:0]                    in_left_x,
  input  wire logic [7:0]                    in_left_y,
  input  wire logic [7:0]                    in_right_x,
  input  wire logic [7:0]                    in_right_y,
  input  wire logic [7:0]                    in_hat_and_face,
  input  wire logic [7:0]                    in_shoulder_and_menu,
  input  wire logic [7:0]                    in_system_buttons,
  input  wire logic [7:0]                    in_left_trigger,
  input  wire logic [7:0]                    in_right_trigger,
  input  wire gpad_pkg::gpad_cmd_t           cmd,
  output gpad_pkg::gpad_sts_t                sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [gpad_pkg::CODE_W-1:0]        out_event_code,
  output logic [gpad_pkg::VAL_W-1:0]         out_event_value,
  output logic                               out_last_event
);

  gpad_pkg::axes_t cur_axes_r, prev_axes_r;
  gpad_pkg::btns_t cur_bits_r, prev_bits_r;
  logic [gpad_pkg::CODE_W-1:0] idx_r, idx_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [gpad_pkg::CODE_W-1:0] code_r;
  logic [gpad_pkg::VAL_W-1:0]  value_r;
  logic last_r;

  logic [gpad_pkg::EVENT_COUNT-1:0][gpad_pkg::VAL_W-1:0] cur_val;
  logic [gpad_pkg::EVENT_COUNT-1:0] changed;
  logic [gpad_pkg::EVENT_COUNT-1:0] later;

  // per-event values and change flags
  always_comb begin
    for (int i = 0; i < gpad_pkg::EVENT_COUNT; i++) begin
      cur_val[i] = gpad_pkg::event_value(cur_axes_r, cur_bits_r, i);
      changed[i] = cur_val[i] != gpad_pkg::event_value(prev_axes_r, prev_bits_r, i);
    end
  end

  // changes beyond the current index
  assign later = (changed >> idx_r) >> 1;

  assign sts.changed  = changed[idx_r];
  assign sts.idx_last = idx_r == gpad_pkg::EV_LAST;
  assign sts.out_free = !out_valid_r || out_ready;

  // report registers: previous takes the old current on each capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_axes_r  <= '0;
      prev_axes_r <= '0;
      cur_bits_r  <= '0;
      prev_bits_r <= '0;
    end else if (cmd.load) begin
      prev_axes_r <= cur_axes_r;
      prev_bits_r <= cur_bits_r;
      cur_axes_r  <= {in_right_trigger, in_left_trigger, in_right_y,
                      in_right_x, in_left_y, in_left_x};
      cur_bits_r  <= gpad_pkg::decode_bits(in_hat_and_face, in_shoulder_and_menu,
                                           in_system_buttons);
    end
  end

  // scan index
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.step && !sts.idx_last) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  // output word valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      code_r  <= idx_r;
      value_r <= cur_val[idx_r];
      last_r  <= later == '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_code  = code_r;
  assign out_event_value = value_r;
  assign out_last_event  = last_r;

endmodule
`default_nettype wire

// ===== hw/rtl/gamepad_report_change_events.sv =====
// top level of the gamepad report change-event decoder
//
//  channel | direction | words per report | handshake
//  in_*    | input     | 1                | in_valid / in_ready
//  out_*   | output    | 0 to 22          | out_valid / out_ready
//
// a report is first captured, then the scan index walks all 22 events
// in order; a changed event holds the scan while the output word is
// stalled. in_ready is high only between reports, while the last
// word may still wait at the output. reset clears the previous values,
// so the first report emits every nonzero event.
`default_nettype none
module gamepad_report_change_events (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_left_x,
  input  wire logic [7:0] in_left_y,
  input  wire logic [7:0] in_right_x,
  input  wire logic [7:0] in_right_y,
  input  wire logic [7:0] in_hat_and_face,
  input  wire logic [7:0] in_shoulder_and_menu,
  input  wire logic [7:0] in_system_buttons,
  input  wire logic [7:0] in_left_trigger,
  input  wire logic [7:0] in_right_trigger,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [4:0]      out_event_code,
  output logic [7:0]      out_event_value,
  output logic            out_last_event
);

  gpad_pkg::gpad_cmd_t cmd;
  gpad_pkg::gpad_sts_t sts;

  // sequencer
  gpad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // event compare and output word
  gpad_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_left_x            (in_left_x),
    .in_left_y            (in_left_y),
    .in_right_x           (in_right_x),
    .in_right_y           (in_right_y),
    .in_hat_and_face      (in_hat_and_face),
    .in_shoulder_and_menu (in_shoulder_and_menu),
    .in_system_buttons    (in_system_buttons),
    .in_left_trigger      (in_left_trigger),
    .in_right_trigger     (in_right_trigger),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_event_code       (out_event_code),
    .out_event_value      (out_event_value),
    .out_last_event       (out_last_event)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/gpad_chk.sv =====
// port-level checker for the change-event decoder and its bind
`default_nettype none
module gpad_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [4:0] out_event_code,
  input wire logic [7:0] out_event_value,
  input wire logic       out_last_event
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_code)
      && $stable(out_event_value) && $stable(out_last_event))
    else $error("output word changed while stalled");

  // codes stay within the event list
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_code <= gpad_pkg::EV_LAST)
    else $error("event code out of range");

  // a captured report is scanned before the next one is taken
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a capture");

  // nothing pending out of reset
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind gamepad_report_change_events gpad_chk u_gpad_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_event_code  (out_event_code),
  .out_event_value (out_event_value),
  .out_last_event  (out_last_event)
);
`default_nettype wire
